// File: rtl/core/eslr_pkg.sv
`timescale 1ns / 1ps

package eslr_pkg;

  // fixed field widths
  localparam int ROW_W    = 12;
  localparam int COL_W    = 13;
  localparam int CNT_W    = 14;
  localparam int RCNT_W   = 13;
  localparam int CH_W     = 3;
  localparam int SAMPLE_W = 16;
  localparam int LANES    = 4;
  localparam int SUM_W    = 30;
  localparam int LEN_W    = 14;
  localparam int COS_W    = 17;
  localparam int SEC_W    = 28;
  localparam int IDX_W    = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_ROW_COUNT     = 2'd0;
  localparam logic [IDX_W-1:0] REG_COLUMN_COUNT  = 2'd1;
  localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;
  localparam logic [IDX_W-1:0] REG_UNLISTED      = 2'd3;

  // pi/2 in Q30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // one finished bin on its way to the averaging stage
  typedef struct packed {
    logic [ROW_W-1:0]                row;
    logic [COL_W-1:0]                col;
    logic [LEN_W-1:0]                len;
    logic [LANES-1:0][SUM_W-1:0]     sums;
  } bin_t;

  // unsigned shift and subtract division for elaboration-time tables
  function automatic longint unsigned udiv64(input longint unsigned a,
                                             input longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // sine of a Q30 angle by nine Taylor terms, rounded to Q1.16
  function automatic logic [COS_W-1:0] sine_q16(input longint unsigned x);
    longint unsigned term;
    longint          acc;
    longint unsigned q;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = udiv64(term, 64'((2 * n) * (2 * n + 1)));
      if ((n & 1) == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    q = (longint'(acc) + 64'd8192) >> 14;
    if (q > 64'd65536) q = 64'd65536;
    return q[COS_W-1:0];
  endfunction

endpackage

// File: rtl/core/equirect_to_sinusoidal_line_resampler.sv
`timescale 1ns / 1ps

// Equirectangular to sinusoidal line resampler. Source pixels enter row-major
// on the s_axis side, one transaction per pixel; each destination column of a
// line's sinusoidal band leaves on m_axis as the rounded mean of its run of
// source pixels, with its row and column. Columns outside the band are never
// sent. Within a line a pixel is taken every cycle while the averaging stage
// keeps up: each output pixel goes through the per-lane bit-serial dividers
// of the averaging stage, which take a new bin only once they are through
// with the last, and a two-entry queue lets the input run ahead of that. At
// the start of every line the input is held while the row index and the
// secant go through the shared divider and the sine table. A configuration
// write to a listed register restarts the frame at row 0.
module equirect_to_sinusoidal_line_resampler #(
  parameter int PIXEL_BITS       = 16,
  parameter int MAX_CHANNELS     = 4,
  parameter int MAX_COLUMNS      = 8192,
  parameter int MAX_ROWS         = 4096,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data,
  // source pixels
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // sample_c0, sample_c1, sample_c2, sample_c3
  // destination pixels
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata   // out_row, out_column, mean_c0..mean_c3, zero pad
);

  logic                                                  cfg_write;
  logic [eslr_pkg::LANES-1:0][eslr_pkg::SAMPLE_W-1:0]   samples;
  logic [eslr_pkg::LANES-1:0][eslr_pkg::SAMPLE_W-1:0]   means;
  logic [eslr_pkg::ROW_W-1:0]                            out_row;
  logic [eslr_pkg::COL_W-1:0]                            out_column;
  logic           q_full;
  logic           push;
  eslr_pkg::bin_t push_data;
  logic           pop;
  logic           head_valid;
  eslr_pkg::bin_t head;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid;
  assign samples   = s_axis_tdata;

  eslr_front #(
    .PIXEL_BITS       (PIXEL_BITS),
    .MAX_CHANNELS     (MAX_CHANNELS),
    .MAX_COLUMNS      (MAX_COLUMNS),
    .MAX_ROWS         (MAX_ROWS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .samples   (samples),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  eslr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  eslr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_row    (out_row),
    .out_column (out_column),
    .out_mean   (means)
  );

  // output packing
  assign m_axis_tdata = {7'b0, means, out_column, out_row};

endmodule

// File: rtl/core/eslr_divider.sv
`timescale 1ns / 1ps

module eslr_divider #(
  parameter int N_W = 29,
  parameter int D_W = 17
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           clear,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           busy,
  output logic           done,
  output logic [N_W-1:0] quotient
);

  localparam int C_W = $clog2(N_W + 1);

  logic [C_W-1:0] cnt;
  logic [D_W-1:0] rem;
  logic [D_W-1:0] div_q;
  logic [N_W-1:0] quo;
  logic [D_W:0]   trial;
  logic           ge;

  // restoring step, one quotient bit a cycle
  assign trial = {rem, quo[N_W-1]};
  assign ge    = (trial >= {1'b0, div_q});

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= C_W'(N_W);
        rem   <= '0;
        quo   <= dividend;
        div_q <= divisor;
      end else if (busy) begin
        quo <= {quo[N_W-2:0], ge};
        rem <= ge ? D_W'(trial - {1'b0, div_q}) : trial[D_W-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == C_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// File: rtl/core/eslr_front.sv
`timescale 1ns / 1ps

module eslr_front #(
  parameter int PIXEL_BITS       = 16,
  parameter int MAX_CHANNELS     = 4,
  parameter int MAX_COLUMNS      = 8192,
  parameter int MAX_ROWS         = 4096,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           cfg_write,
  input  logic [eslr_pkg::IDX_W-1:0]                     cfg_index,
  input  logic [eslr_pkg::CNT_W-1:0]                     cfg_data,
  input  logic                                           in_valid,
  output logic                                           in_ready,
  input  logic [eslr_pkg::LANES-1:0][eslr_pkg::SAMPLE_W-1:0] samples,
  input  logic                                           q_full,
  output logic                                           push,
  output eslr_pkg::bin_t                                 push_data
);

  localparam int COL_W  = eslr_pkg::COL_W;
  localparam int ROW_W  = eslr_pkg::ROW_W;
  localparam int COS_W  = eslr_pkg::COS_W;
  localparam int SEC_W  = eslr_pkg::SEC_W;
  localparam int SUM_W  = eslr_pkg::SUM_W;
  localparam int LEN_W  = eslr_pkg::LEN_W;
  localparam int LANES  = eslr_pkg::LANES;
  localparam int NUM_W  = COL_W + SEC_W + 4;
  localparam int DN_W   = SEC_W + 1;
  localparam int K_W    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam logic [DN_W-1:0] DEPTH2 = DN_W'(2 * SINE_TABLE_DEPTH);
  localparam logic [DN_W-1:0] DEPTH1 = DN_W'(SINE_TABLE_DEPTH);
  localparam logic [eslr_pkg::SAMPLE_W-1:0] PMASK =
    eslr_pkg::SAMPLE_W'((32'd1 << PIXEL_BITS) - 32'd1);

  // quarter sine table, built at elaboration
  typedef logic [COS_W-1:0] rom_t [SINE_TABLE_DEPTH+1];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
      r[k] = eslr_pkg::sine_q16(eslr_pkg::udiv64(eslr_pkg::HALF_PI_Q30 * 64'(k),
                                                 64'(SINE_TABLE_DEPTH)));
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // bin end rounded half away from zero, clamped into [lo, hi]
  function automatic logic [COL_W-1:0] clamp_end(input logic signed [NUM_W-1:0] n,
                                                 input logic [COL_W:0] lo,
                                                 input logic [COL_W-1:0] hi);
    logic [NUM_W-1:0] v;
    v = (unsigned'(n) + NUM_W'(4096)) >> 13;
    if (n < 0) v = NUM_W'(lo);
    if (v < NUM_W'(lo)) v = NUM_W'(lo);
    if (v > NUM_W'(hi)) v = NUM_W'(hi);
    return v[COL_W-1:0];
  endfunction

  typedef enum logic [3:0] {
    S_KMUL, S_KDIV, S_KWAIT, S_ROM, S_ROMQ, S_SEC, S_SWAIT,
    S_MUL, S_BAND, S_PROD, S_BIN, S_RUN
  } state_t;

  state_t state;

  // configuration registers
  logic [eslr_pkg::RCNT_W-1:0] row_count;
  logic [eslr_pkg::CNT_W-1:0]  column_count;
  logic [eslr_pkg::CH_W-1:0]   channel_count;
  logic                        cfg_hit;

  logic [eslr_pkg::RCNT_W-1:0] nrows;
  logic [eslr_pkg::CNT_W-1:0]  ncols;
  logic [eslr_pkg::CH_W-1:0]   nch;
  logic [COL_W-1:0]            nm1;

  // line and bin state
  logic [ROW_W-1:0]              row_counter;
  logic [COL_W-1:0]              source_column;
  logic [COL_W-1:0]              dest_column;
  logic [COL_W-1:0]              bin_end;
  logic [COL_W-1:0]              band_max;
  logic [LEN_W-1:0]              bin_length;
  logic [COS_W-1:0]              row_cosine;
  logic [SEC_W-1:0]              row_secant;
  logic [LANES-1:0][SUM_W-1:0]   channel_sums;
  logic                          finished;
  logic signed [NUM_W-1:0]       num_next;
  logic signed [NUM_W-1:0]       prod_q;
  logic [DN_W-1:0]               k_num;
  logic [K_W-1:0]                k_idx;
  logic [COS_W-1:0]              rom_q;
  logic [COS_W+COL_W-1:0]        p_q;

  // working values
  logic                          accept;
  logic                          close_bin;
  logic [LANES-1:0][SUM_W-1:0]   sums_new;
  logic [LEN_W-1:0]              len_new;
  logic [COL_W:0]                col_inc;
  logic [COL_W+16-1:0]           half;
  logic signed [COL_W+1:0]       diff_s;
  logic signed [SEC_W:0]         sec_s;
  logic signed [NUM_W-1:0]       num_first;
  logic signed [NUM_W-1:0]       two_sec;
  logic [COL_W+18:0]             band_sum;

  // shared divider for the row index and the secant
  logic            div_start;
  logic            div_busy;
  logic            div_done;
  logic [DN_W-1:0] div_n;
  logic [COS_W-1:0] div_d;
  logic [DN_W-1:0] div_q;

  // effective register values
  always_comb begin
    nrows = row_count;
    if (row_count == '0) nrows = eslr_pkg::RCNT_W'(1);
    else if (row_count > eslr_pkg::RCNT_W'(MAX_ROWS)) nrows = eslr_pkg::RCNT_W'(MAX_ROWS);
    ncols = column_count;
    if (column_count == '0) ncols = eslr_pkg::CNT_W'(1);
    else if (column_count > eslr_pkg::CNT_W'(MAX_COLUMNS)) ncols = eslr_pkg::CNT_W'(MAX_COLUMNS);
    nch = channel_count;
    if (channel_count == '0) nch = eslr_pkg::CH_W'(1);
    else if (channel_count > eslr_pkg::CH_W'(MAX_CHANNELS)) nch = eslr_pkg::CH_W'(MAX_CHANNELS);
  end

  assign nm1     = COL_W'(ncols - 1'b1);
  assign cfg_hit = cfg_write && (cfg_index == eslr_pkg::REG_ROW_COUNT ||
                                 cfg_index == eslr_pkg::REG_COLUMN_COUNT ||
                                 cfg_index == eslr_pkg::REG_CHANNEL_COUNT);

  // divider operand selection
  assign div_start = (state == S_KDIV) || (state == S_SEC);
  assign div_n = (state == S_KDIV) ? k_num
                                   : (DN_W'(1) << SEC_W) + DN_W'(row_cosine >> 1);
  assign div_d = (state == S_KDIV) ? COS_W'({nrows, 1'b0}) : row_cosine;

  eslr_divider #(.N_W(DN_W), .D_W(COS_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .clear    (cfg_hit),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // table read, registered
  always_ff @(posedge clk) begin
    rom_q <= SINE_ROM[k_idx];
  end

  // line geometry terms
  assign half      = {nm1, 16'b0};
  assign band_sum  = (COL_W+19)'(half) + (COL_W+19)'(p_q) + (COL_W+19)'(131071);
  assign diff_s    = $signed({1'b0, dest_column, 1'b0}) - $signed({2'b0, nm1});
  assign sec_s     = $signed({1'b0, row_secant});
  assign num_first = $signed({{(NUM_W-COL_W-12){1'b0}}, nm1, 12'b0}) + prod_q;
  assign two_sec   = $signed({{(NUM_W-SEC_W-1){1'b0}}, row_secant, 1'b0});

  // accumulation of one source pixel
  assign in_ready  = (state == S_RUN) && !q_full;
  assign accept    = in_valid && in_ready;
  assign close_bin = accept && !finished && (source_column == bin_end);
  assign len_new   = bin_length + 1'b1;
  assign col_inc   = {1'b0, source_column} + 1'b1;

  always_comb begin
    for (int ch = 0; ch < LANES; ch++) begin
      if (eslr_pkg::CH_W'(ch) < nch)
        sums_new[ch] = channel_sums[ch] + SUM_W'(samples[ch] & PMASK);
      else
        sums_new[ch] = channel_sums[ch];
    end
  end

  assign push           = close_bin;
  assign push_data.row  = row_counter;
  assign push_data.col  = dest_column;
  assign push_data.len  = len_new;
  assign push_data.sums = sums_new;

  // line set-up sequence and per-pixel bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_KMUL;
      row_count     <= eslr_pkg::RCNT_W'(1024);
      column_count  <= eslr_pkg::CNT_W'(2048);
      channel_count <= eslr_pkg::CH_W'(3);
      row_counter   <= '0;
      source_column <= '0;
      finished      <= 1'b0;
    end else if (cfg_hit) begin
      case (cfg_index)
        eslr_pkg::REG_ROW_COUNT:    row_count     <= cfg_data[eslr_pkg::RCNT_W-1:0];
        eslr_pkg::REG_COLUMN_COUNT: column_count  <= cfg_data;
        eslr_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[eslr_pkg::CH_W-1:0];
        default: ;
      endcase
      state         <= S_KMUL;
      row_counter   <= '0;
      source_column <= '0;
      finished      <= 1'b0;
    end else begin
      case (state)
        S_KMUL: begin
          k_num <= DN_W'({row_counter, 1'b1}) * DEPTH2 + DN_W'(nrows);
          state <= S_KDIV;
        end
        S_KDIV: state <= S_KWAIT;
        S_KWAIT: begin
          if (div_done) begin
            k_idx <= (div_q > DEPTH1) ? K_W'(DEPTH2 - div_q) : K_W'(div_q);
            state <= S_ROM;
          end
        end
        S_ROM: state <= S_ROMQ;
        S_ROMQ: begin
          row_cosine <= (rom_q == '0) ? COS_W'(1) : rom_q;
          state      <= S_SEC;
        end
        S_SEC: state <= S_SWAIT;
        S_SWAIT: begin
          if (div_done) begin
            row_secant <= (div_q > DN_W'({SEC_W{1'b1}})) ? {SEC_W{1'b1}} : div_q[SEC_W-1:0];
            state      <= S_MUL;
          end
        end
        S_MUL: begin
          p_q   <= (COS_W+COL_W)'(nm1) * (COS_W+COL_W)'(row_cosine);
          state <= S_BAND;
        end
        S_BAND: begin
          dest_column <= COL_W'(((COL_W+17)'(half) - (COL_W+17)'(p_q)) >> 17);
          band_max    <= COL_W'(band_sum >> 17);
          state       <= S_PROD;
        end
        S_PROD: begin
          prod_q <= diff_s * sec_s;
          state  <= S_BIN;
        end
        S_BIN: begin
          bin_end      <= clamp_end(num_first, '0, nm1);
          num_next     <= num_first + two_sec;
          bin_length   <= '0;
          channel_sums <= '0;
          finished     <= 1'b0;
          state        <= S_RUN;
        end
        S_RUN: begin
          if (accept) begin
            if (!finished) begin
              if (close_bin) begin
                channel_sums <= '0;
                bin_length   <= '0;
                if (dest_column >= band_max || bin_end >= nm1) begin
                  finished <= 1'b1;
                end else begin
                  dest_column <= dest_column + 1'b1;
                  bin_end     <= clamp_end(num_next, col_inc, nm1);
                  num_next    <= num_next + two_sec;
                end
              end else begin
                channel_sums <= sums_new;
                bin_length   <= len_new;
              end
            end
            if (col_inc >= (COL_W+1)'(ncols)) begin
              source_column <= '0;
              state         <= S_KMUL;
              if (eslr_pkg::RCNT_W'(row_counter) + 1'b1 >= nrows)
                row_counter <= '0;
              else
                row_counter <= row_counter + 1'b1;
            end else begin
              source_column <= col_inc[COL_W-1:0];
            end
          end
        end
        default: state <= S_KMUL;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a closed bin always finds room in the queue
  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("bin pushed into a full queue");

  // the shared divider is never restarted mid-division
  a_div_idle: assert property (@(posedge clk) disable iff (rst) div_start |-> !div_busy)
    else $error("divider started while busy");

  // the open bin ends inside the line and not behind the current column
  a_bin_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && !finished) |-> (bin_end <= nm1 && bin_end >= source_column))
    else $error("bin end outside the line");
`endif

endmodule

// File: rtl/core/eslr_queue.sv
`timescale 1ns / 1ps

module eslr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  eslr_pkg::bin_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output eslr_pkg::bin_t head
);

  // two fixed slots, slot0 is the head
  eslr_pkg::bin_t slot0;
  eslr_pkg::bin_t slot1;
  logic [1:0]     count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slot0;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push && !pop) begin
      count <= count + 1'b1;
    end else if (pop && !push) begin
      count <= count - 1'b1;
    end
  end

  // slot shifting
  always_ff @(posedge clk) begin
    if (pop) begin
      slot0 <= (count == 2'd2) ? slot1 : push_data;
      if (push) slot1 <= push_data;
    end else if (push) begin
      if (count == 2'd0) slot0 <= push_data;
      else slot1 <= push_data;
    end
  end

endmodule

// File: rtl/core/eslr_back.sv
`timescale 1ns / 1ps

module eslr_back (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              head_valid,
  input  eslr_pkg::bin_t                                    head,
  output logic                                              pop,
  output logic                                              out_valid,
  input  logic                                              out_ready,
  output logic [eslr_pkg::ROW_W-1:0]                        out_row,
  output logic [eslr_pkg::COL_W-1:0]                        out_column,
  output logic [eslr_pkg::LANES-1:0][eslr_pkg::SAMPLE_W-1:0] out_mean
);

  localparam int N_W = eslr_pkg::SUM_W + 1;
  localparam int D_W = eslr_pkg::LEN_W + 1;

  typedef enum logic [1:0] {B_IDLE, B_BUSY, B_HOLD} state_t;

  state_t state;
  logic [eslr_pkg::ROW_W-1:0] row_q;
  logic [eslr_pkg::COL_W-1:0] col_q;
  logic [eslr_pkg::LANES-1:0]          done;
  logic [eslr_pkg::LANES-1:0]          busy;
  logic [eslr_pkg::LANES-1:0][N_W-1:0] quo;
  logic                                start;
  logic                                load;

  assign start = (state == B_IDLE) && head_valid;
  assign pop   = start;
  assign load  = (state == B_HOLD) && (!out_valid || out_ready);

  // rounded mean per lane: (2*sum + n) / (2*n)
  for (genvar ch = 0; ch < eslr_pkg::LANES; ch++) begin : g_lane
    eslr_divider #(.N_W(N_W), .D_W(D_W)) u_div (
      .clk      (clk),
      .rst      (rst),
      .clear    (1'b0),
      .start    (start),
      .dividend ({head.sums[ch], 1'b0} + N_W'(head.len)),
      .divisor  ({head.len, 1'b0}),
      .busy     (busy[ch]),
      .done     (done[ch]),
      .quotient (quo[ch])
    );
  end

  // sequencing and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !load) out_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (start) begin
            row_q <= head.row;
            col_q <= head.col;
            state <= B_BUSY;
          end
        end
        B_BUSY: begin
          if (done[0]) state <= B_HOLD;
        end
        B_HOLD: begin
          if (load) begin
            out_valid  <= 1'b1;
            out_row    <= row_q;
            out_column <= col_q;
            for (int ch = 0; ch < eslr_pkg::LANES; ch++)
              out_mean[ch] <= quo[ch][eslr_pkg::SAMPLE_W-1:0];
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // all lane dividers run in lock step
  a_lanes_busy: assert property (@(posedge clk) disable iff (rst)
    busy == {eslr_pkg::LANES{busy[0]}})
    else $error("lane dividers out of step");

  a_lanes_done: assert property (@(posedge clk) disable iff (rst)
    done == {eslr_pkg::LANES{done[0]}})
    else $error("lane dividers finished apart");

  // a new bin is only taken while the dividers are idle
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy[0])
    else $error("bin taken while dividing");
`endif

endmodule

// File: bench/equirect_to_sinusoidal_line_resampler_tb.sv
`timescale 1ns / 1ps

module equirect_to_sinusoidal_line_resampler_tb;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 160;
  localparam int PIXELS      = 1250;

  // tracks the line geometry and the running bin sums, holds the awaited means
  class band_mean_scoreboard;
    int unsigned rows_reg, cols_reg, chans_reg;
    int unsigned row_ctr, src_col, dst_col, bin_last, bin_len, cos_q16, sec_q12;
    longint unsigned lane_sum[eslr_pkg::LANES];
    bit line_done;
    logic [95:0] pending_means[$];
    int errors, results, lines;

    function new();
      rows_reg  = 1024;
      cols_reg  = 2048;
      chans_reg = 3;
      restart();
    endfunction

    function void restart();
      row_ctr = 0; src_col = 0; dst_col = 0; bin_last = 0; bin_len = 0;
      cos_q16 = 0; sec_q12 = 0; line_done = 0;
      foreach (lane_sum[i]) lane_sum[i] = 0;
    endfunction

    function int unsigned clamp_to(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    // quarter sine entry in Q1.16 by a nine-term series in Q30
    function int unsigned quarter_sine(int unsigned k);
      longint unsigned x, term, q;
      longint acc;
      x = eslr_pkg::HALF_PI_Q30 * k / 1024;
      term = x;
      acc = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / ((2 * n) * (2 * n + 1));
        if (n % 2) acc -= longint'(term);
        else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      q = (unsigned'(acc) + 8192) >> 14;
      if (q > 65536) q = 65536;
      return q;
    endfunction

    function int unsigned bin_end_for(int unsigned d, int unsigned first, int unsigned n);
      longint num, r;
      num = longint'(n - 1) * 4096 + (2 * longint'(d) - longint'(n - 1)) * longint'(sec_q12);
      if (num >= 0) r = (num + 4096) >>> 13;
      else r = -((-num + 4096) >>> 13);
      if (r < longint'(first)) r = first;
      if (r > longint'(n - 1)) r = n - 1;
      return r;
    endfunction

    function void open_line(int unsigned nrows, int unsigned ncols);
      longint unsigned k, sec, half;
      k = ((2 * longint'(row_ctr) + 1) * 2048 + nrows) / (2 * longint'(nrows));
      if (k > 1024) k = 2048 - k;
      cos_q16 = quarter_sine(k);
      if (cos_q16 < 1) cos_q16 = 1;
      sec = ((64'd1 << 28) + cos_q16 / 2) / cos_q16;
      if (sec > 64'h0FFF_FFFF) sec = 64'h0FFF_FFFF;
      sec_q12 = sec;
      half = longint'(ncols - 1) << 16;
      dst_col = (half - longint'(ncols - 1) * cos_q16) >> 17;
      bin_last = bin_end_for(dst_col, 0, ncols);
      bin_len = 0;
      foreach (lane_sum[i]) lane_sum[i] = 0;
      line_done = 0;
      lines++;
    endfunction

    function void write_reg(logic [1:0] idx, logic [13:0] data);
      if (idx == eslr_pkg::REG_ROW_COUNT) rows_reg = data[12:0];
      else if (idx == eslr_pkg::REG_COLUMN_COUNT) cols_reg = data;
      else if (idx == eslr_pkg::REG_CHANNEL_COUNT) chans_reg = data[2:0];
      else return;
      restart();
    endfunction

    // one source pixel in; a finished bin queues its mean pixel
    function void predict_band_pixel(logic [63:0] px);
      int unsigned ncols, nrows, nch;
      longint unsigned top;
      logic [95:0] mean_px;
      ncols = clamp_to(cols_reg, 8192);
      nrows = clamp_to(rows_reg, 4096);
      nch   = clamp_to(chans_reg, 4);
      if (src_col == 0) open_line(nrows, ncols);
      if (!line_done) begin
        for (int c = 0; c < nch; c++) lane_sum[c] += px[c*16 +: 16];
        bin_len++;
        if (src_col == bin_last) begin
          mean_px = '0;
          mean_px[11:0]  = row_ctr;
          mean_px[24:12] = dst_col;
          for (int c = 0; c < nch; c++)
            mean_px[25 + c*16 +: 16] = (2 * lane_sum[c] + bin_len) / (2 * longint'(bin_len));
          pending_means.push_back(mean_px);
          foreach (lane_sum[i]) lane_sum[i] = 0;
          bin_len = 0;
          top = ((longint'(ncols - 1) << 16) + longint'(ncols - 1) * cos_q16 + 131071) >> 17;
          if (dst_col >= top || bin_last >= ncols - 1) line_done = 1;
          else begin
            dst_col++;
            bin_last = bin_end_for(dst_col, src_col + 1, ncols);
          end
        end
      end
      src_col++;
      if (src_col >= ncols) begin
        src_col = 0;
        row_ctr++;
        if (row_ctr >= nrows) row_ctr = 0;
      end
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [95:0] got);
      logic [95:0] want;
      string names[7] = '{"out_row", "out_column", "mean_c0", "mean_c1", "mean_c2",
                          "mean_c3", "pad"};
      int lo[7] = '{0, 12, 25, 41, 57, 73, 89};
      int wd[7] = '{12, 13, 16, 16, 16, 16, 7};
      if (pending_means.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel %h", got));
        return;
      end
      want = pending_means.pop_front();
      results++;
      for (int f = 0; f < 7; f++) begin
        if (((got >> lo[f]) & ((96'd1 << wd[f]) - 1)) != ((want >> lo[f]) & ((96'd1 << wd[f]) - 1)))
          report_mismatch($sformatf("%s got %0d want %0d (row %0d col %0d)", names[f],
                          (got >> lo[f]) & ((96'd1 << wd[f]) - 1),
                          (want >> lo[f]) & ((96'd1 << wd[f]) - 1), want[11:0], want[24:12]));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [13:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // sample_c0, sample_c1, sample_c2, sample_c3
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;   // out_row, out_column, mean_c0..mean_c3, zero pad

  band_mean_scoreboard sb;
  int cycles = 0;
  int pixels_sent;
  int stall_mode;
  int stall_ctr = 0;
  int burst_max;
  int gap_max;

  equirect_to_sinusoidal_line_resampler uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // transaction monitor on all three channels
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready) sb.predict_band_pixel(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    stall_ctr <= stall_ctr + 1;
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= ((stall_ctr % 97) > 60);
      default: m_axis_tready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("equirect_to_sinusoidal_line_resampler_tb failed");
      $finish;
    end
  end

  task write_reg(logic [1:0] idx, logic [13:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task send_pixel(logic [63:0] px);
    s_axis_tdata  <= px;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pixels_sent++;
  endtask

  task hold_off(int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // wait for every awaited pixel, then let the line-start work settle
  task drain();
    hold_off(1);
    while (sb.pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function logic [63:0] random_pixel();
    logic [63:0] px;
    for (int c = 0; c < 4; c++) begin
      case ($urandom_range(0, 7))
        0: px[c*16 +: 16] = 16'h0000;
        1: px[c*16 +: 16] = 16'hFFFF;
        default: px[c*16 +: 16] = $urandom;
      endcase
    end
    return px;
  endfunction

  // bursts of random length separated by random gaps
  task send_bursts(int n);
    int left, burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, burst_max);
      if (burst > left) burst = left;
      repeat (burst) send_pixel(random_pixel());
      left -= burst;
      if (gap_max > 0) hold_off($urandom_range(0, gap_max));
    end
  endtask

  task configure(logic [13:0] rows, logic [13:0] cols, logic [13:0] chans);
    drain();
    write_reg(eslr_pkg::REG_ROW_COUNT, rows);
    write_reg(eslr_pkg::REG_COLUMN_COUNT, cols);
    write_reg(eslr_pkg::REG_CHANNEL_COUNT, chans);
  endtask

  initial begin
    logic [63:0] directed[$];
    logic [13:0] rows, cols;
    int n;
    sb = new();
    rst = 1'b1;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    pixels_sent = 0; stall_mode = 0;
    burst_max = 30; gap_max = 4;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // a few pixels on the reset geometry
    send_bursts(10);

    // directed: small image, all four lanes, extreme and alternating values
    configure(14'd4, 14'd8, 14'd4);
    directed = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_AAAA_5555_AAAA,
                 64'hAAAA_5555_AAAA_5555, 64'h0001_0000_FFFE_8000, 64'h7FFF_8000_0001_FFFF,
                 64'hFFFF_0000_FFFF_0000, 64'h0000_FFFF_0000_FFFF};
    for (int i = 0; i < 24; i++) begin
      if (i < directed.size()) send_pixel(directed[i]);
      else if (i % 3 == 0) send_pixel(64'hFFFF_FFFF_FFFF_FFFF);
      else send_pixel(random_pixel());
    end

    // register extremes and an unlisted index
    configure(14'd0, 14'd0, 14'd0);
    write_reg(eslr_pkg::REG_UNLISTED, 14'h3FFF);
    send_bursts(8);
    configure(14'h3FFF, 14'd3, 14'd7);
    send_bursts(60);
    stall_mode = 2;
    configure(14'd1, 14'h3FFF, 14'd1);
    send_bursts(300);
    stall_mode = 1;
    configure(14'd4096, 14'd8192, 14'd4);
    send_bursts(40);

    // random geometries, most with short lines
    while (pixels_sent < PIXELS) begin
      stall_mode = $urandom_range(0, 3);
      burst_max = $urandom_range(1, 60);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      rows = $urandom_range(1, 12);
      cols = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 48);
      configure(rows, cols, $urandom_range(0, 7));
      n = $urandom_range(20, 120);
      send_bursts(n / 2);
      // sender waits for the block to empty mid-image
      hold_off(1);
      while (sb.pending_means.size() != 0) @(posedge clk);
      send_bursts(n - n / 2);
    end

    drain();
    $display("pixels in: %0d, mean pixels checked: %0d, lines started: %0d",
             pixels_sent, sb.results, sb.lines);
    $display("geometries from 1x1 up to 4096x8192, one to four lanes, mixed stalls");
    if (sb.errors == 0 && sb.pending_means.size() == 0) begin
      $display("equirect_to_sinusoidal_line_resampler_tb passed");
    end else begin
      $display("equirect_to_sinusoidal_line_resampler_tb failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/eslr_pkg.sv
rtl/core/eslr_divider.sv
rtl/core/eslr_front.sv
rtl/core/eslr_queue.sv
rtl/core/eslr_back.sv
rtl/core/equirect_to_sinusoidal_line_resampler.sv
bench/equirect_to_sinusoidal_line_resampler_tb.sv
